// ----- hdl/itp_pkg.sv -----
// itp_pkg: shared types, codes and default sizes of the isometric tile picker
// no dependencies; imported by every module of the block but itp_ram

package itp_pkg;

  // fixed field widths
  localparam int PT_W       = 12;
  localparam int IDX_W      = 5;
  localparam int CORNER_W   = 3;
  localparam int ORIGIN_W   = 16;
  localparam int CFG_IDX_W  = 1;

  // biased offset fed to the dividers is unsigned and below 2**DIVW
  localparam int DIVW       = 17;
  // signed width of offsets and iso indices
  localparam int IW         = DIVW + 2;
  // largest negative offset from the origin: point at 0, origin at its maximum
  localparam int NEG_SPAN   = 2 ** (ORIGIN_W - 1) - 1;

  // queue between front and back
  localparam int QDEPTH     = 2;

  // default grid and tile sizes
  localparam int DEF_GRID_COLUMNS     = 32;
  localparam int DEF_GRID_ROWS        = 32;
  localparam int DEF_HALF_TILE_WIDTH  = 32;
  localparam int DEF_HALF_TILE_HEIGHT = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 1'b1;

  // operation codes
  localparam logic OP_PICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // corner step codes
  localparam logic [CORNER_W-1:0] CORNER_NONE = 3'd0;
  localparam logic [CORNER_W-1:0] CORNER_LT   = 3'd1;
  localparam logic [CORNER_W-1:0] CORNER_RT   = 3'd2;
  localparam logic [CORNER_W-1:0] CORNER_LB   = 3'd3;
  localparam logic [CORNER_W-1:0] CORNER_RB   = 3'd4;

  // one classified item waiting for the back end
  typedef struct packed {
    logic             op;
    logic [DIVW-1:0]  ax;
    logic [DIVW-1:0]  ay;
    logic [IDX_W-1:0] qc;
    logic [IDX_W-1:0] qr;
  } itp_item_t;

endpackage

// ----- hdl/isometric_tile_picker_unit.sv -----
// isometric_tile_picker_unit: top level with configuration registers and checks
// depends on itp_pkg, itp_front, itp_fifo and itp_back

// Picks the diamond tile under a screen point and marks it in a selection
// bitmap (op 0), or reads one tile's mark (op 1). Each beat yields exactly one
// result beat. The back-end sequencer handles one item at a time, in the steps
// queue pop, reciprocal divide, remainder and rotation, edge test, neighbor
// step, bitmap access and result load, and takes no new item before it has
// loaded the last result. A two-entry queue keeps taking beats while the back
// end works or a result waits, until it is full. After reset the bitmap is
// cleared one entry per cycle, all GRID_COLUMNS*GRID_ROWS entries (1024 with
// the defaults), during which in_stall is high; configuration writes are taken
// at any time.

module isometric_tile_picker_unit #(
  parameter int GRID_COLUMNS     = itp_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS        = itp_pkg::DEF_GRID_ROWS,
  parameter int HALF_TILE_WIDTH  = itp_pkg::DEF_HALF_TILE_WIDTH,
  parameter int HALF_TILE_HEIGHT = itp_pkg::DEF_HALF_TILE_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [itp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [itp_pkg::ORIGIN_W-1:0]    cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic [itp_pkg::PT_W-1:0]        in_point_x,
  input  logic [itp_pkg::PT_W-1:0]        in_point_y,
  input  logic [itp_pkg::IDX_W-1:0]       in_query_col,
  input  logic [itp_pkg::IDX_W-1:0]       in_query_row,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic [itp_pkg::IDX_W-1:0]       out_tile_col,
  output logic [itp_pkg::IDX_W-1:0]       out_tile_row,
  output logic [itp_pkg::CORNER_W-1:0]    out_corner,
  output logic                            out_marked
);

  import itp_pkg::*;

  logic signed [ORIGIN_W-1:0] origin_x_r, origin_x_nxt;
  logic signed [ORIGIN_W-1:0] origin_y_r, origin_y_nxt;

  logic       clear_done;
  logic       q_full, q_empty, push, pop;
  itp_item_t  push_item, q_item;

  // configuration registers
  always_comb begin
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x_nxt = $signed(cfg_wdata);
        REG_ORIGIN_Y: origin_y_nxt = $signed(cfg_wdata);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else begin
      origin_x_r <= origin_x_nxt;
      origin_y_r <= origin_y_nxt;
    end
  end

  itp_front #(
    .HALF_TILE_WIDTH  (HALF_TILE_WIDTH),
    .HALF_TILE_HEIGHT (HALF_TILE_HEIGHT)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_query_col (in_query_col),
    .in_query_row (in_query_row),
    .origin_x     (origin_x_r),
    .origin_y     (origin_y_r),
    .clear_done   (clear_done),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  itp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  itp_back #(
    .GRID_COLUMNS     (GRID_COLUMNS),
    .GRID_ROWS        (GRID_ROWS),
    .HALF_TILE_WIDTH  (HALF_TILE_WIDTH),
    .HALF_TILE_HEIGHT (HALF_TILE_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_item       (q_item),
    .pop          (pop),
    .clear_done   (clear_done),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hit      (out_hit),
    .out_tile_col (out_tile_col),
    .out_tile_row (out_tile_row),
    .out_corner   (out_corner),
    .out_marked   (out_marked)
  );

  // no result can appear before the bitmap sweep has finished
  a_no_result_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n)
    !clear_done |-> !out_valid
  ) else $error("result beat while bitmap is still clearing");

  // a hit always reports its tile as marked
  a_hit_marked: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> out_marked
  ) else $error("hit without mark");

  // a miss or a read carries no corner step
  a_miss_no_corner: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_corner == CORNER_NONE)
  ) else $error("corner reported without a hit");

  // the back end pops only from a non-empty queue
  a_pop_nonempty: assert property (
    @(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty
  ) else $error("queue popped while empty");

endmodule

// ----- hdl/itp_ram.sv -----
// itp_ram: generic single-write, single-read memory with registered read data
// no package dependency

module itp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/itp_fifo.sv -----
// itp_fifo: short item queue between the front and the back end
// depends on itp_pkg for the item type and depth

module itp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  itp_pkg::itp_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output itp_pkg::itp_item_t  pop_item,
  output logic                empty
);

  import itp_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  itp_item_t        q_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;

  assign full     = (count_r == QCW'(QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = q_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- hdl/itp_front.sv -----
// itp_front: input beat acceptance and offset preparation for the dividers
// depends on itp_pkg; feeds itp_fifo

module itp_front #(
  parameter int HALF_TILE_WIDTH  = itp_pkg::DEF_HALF_TILE_WIDTH,
  parameter int HALF_TILE_HEIGHT = itp_pkg::DEF_HALF_TILE_HEIGHT
) (
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [itp_pkg::PT_W-1:0]             in_point_x,
  input  logic [itp_pkg::PT_W-1:0]             in_point_y,
  input  logic [itp_pkg::IDX_W-1:0]            in_query_col,
  input  logic [itp_pkg::IDX_W-1:0]            in_query_row,
  input  logic signed [itp_pkg::ORIGIN_W-1:0]  origin_x,
  input  logic signed [itp_pkg::ORIGIN_W-1:0]  origin_y,
  input  logic                                 clear_done,
  input  logic                                 q_full,
  output logic                                 push,
  output itp_pkg::itp_item_t                   push_item
);

  import itp_pkg::*;

  localparam int BOX_W  = 2 * HALF_TILE_WIDTH;
  localparam int BOX_H  = 2 * HALF_TILE_HEIGHT;
  // whole boxes added so that the offset never goes negative
  localparam int KX     = (NEG_SPAN + BOX_W - 1) / BOX_W;
  localparam int KY     = (NEG_SPAN + BOX_H - 1) / BOX_H;
  localparam int BIAS_X = KX * BOX_W;
  localparam int BIAS_Y = KY * BOX_H;

  logic signed [IW-1:0] ax_s;
  logic signed [IW-1:0] ay_s;

  // hold off while the bitmap clears or the queue is full
  assign in_stall = !clear_done || q_full;
  assign push     = in_valid && !in_stall;

  // offset from the origin plus the bias, always positive
  assign ax_s = $signed(IW'(in_point_x)) - IW'(origin_x) + IW'(BIAS_X);
  assign ay_s = $signed(IW'(in_point_y)) - IW'(origin_y) + IW'(BIAS_Y);

  always_comb begin
    push_item.op = in_op;
    push_item.ax = ax_s[DIVW-1:0];
    push_item.ay = ay_s[DIVW-1:0];
    push_item.qc = in_query_col;
    push_item.qr = in_query_row;
  end

endmodule

// ----- hdl/itp_back.sv -----
// itp_back: sequencer that divides, tests the diamond edge, steps and updates the bitmap
// depends on itp_pkg and itp_ram; drains itp_fifo and drives the result channel

module itp_back #(
  parameter int GRID_COLUMNS     = itp_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS        = itp_pkg::DEF_GRID_ROWS,
  parameter int HALF_TILE_WIDTH  = itp_pkg::DEF_HALF_TILE_WIDTH,
  parameter int HALF_TILE_HEIGHT = itp_pkg::DEF_HALF_TILE_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  itp_pkg::itp_item_t             q_item,
  output logic                           pop,
  output logic                           clear_done,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_hit,
  output logic [itp_pkg::IDX_W-1:0]      out_tile_col,
  output logic [itp_pkg::IDX_W-1:0]      out_tile_row,
  output logic [itp_pkg::CORNER_W-1:0]   out_corner,
  output logic                           out_marked
);

  import itp_pkg::*;

  localparam int BOX_W = 2 * HALF_TILE_WIDTH;
  localparam int BOX_H = 2 * HALF_TILE_HEIGHT;
  localparam int KX    = (NEG_SPAN + BOX_W - 1) / BOX_W;
  localparam int KY    = (NEG_SPAN + BOX_H - 1) / BOX_H;
  localparam int BXW   = $clog2(BOX_W);
  localparam int BYW   = $clog2(BOX_H);

  // reciprocal constants: floor(a * M >> S) equals floor(a / box) for a < 2**DIVW
  localparam int SX = DIVW + BXW;
  localparam int SY = DIVW + BYW;
  localparam longint MX_L = ((64'd1 << SX) + longint'(BOX_W) - 1) / longint'(BOX_W);
  localparam longint MY_L = ((64'd1 << SY) + longint'(BOX_H) - 1) / longint'(BOX_H);
  localparam logic [SX-1:0] MX = SX'(MX_L);
  localparam logic [SY-1:0] MY = SY'(MY_L);

  localparam int DEPTH = GRID_COLUMNS * GRID_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

  localparam int EW = 20;
  localparam logic signed [EW-1:0] HTW_S  = EW'(HALF_TILE_WIDTH);
  localparam logic signed [EW-1:0] HTH_S  = EW'(HALF_TILE_HEIGHT);
  localparam logic signed [IW-1:0] KX_S   = IW'(KX);
  localparam logic signed [IW-1:0] KY_S   = IW'(KY);
  localparam logic signed [IW-1:0] COLS_S = IW'(GRID_COLUMNS);
  localparam logic signed [IW-1:0] ROWS_S = IW'(GRID_ROWS);

  // sequencer states
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_REM  = 3'd3;
  localparam logic [2:0] ST_EDGE = 3'd4;
  localparam logic [2:0] ST_STEP = 3'd5;
  localparam logic [2:0] ST_MEM  = 3'd6;
  localparam logic [2:0] ST_LOAD = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [AW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 load;

  itp_item_t            item_r;
  logic [DIVW-1:0]      qx_r, qy_r;
  logic [BXW-1:0]       lx_r;
  logic [BYW-1:0]       ly_r;
  logic signed [IW-1:0] ic_r, ir_r;
  logic [CORNER_W-1:0]  corner_r;
  logic                 hit_r, look_r;
  logic [AW-1:0]        addr_r;
  logic [IDX_W-1:0]     col_r, row_r;
  logic [CORNER_W-1:0]  cor_r;

  logic                 out_hit_r;
  logic [IDX_W-1:0]     out_col_r, out_row_r;
  logic [CORNER_W-1:0]  out_corner_r;
  logic                 out_marked_r;

  logic [DIVW+SX-1:0]   prod_x;
  logic [DIVW+SY-1:0]   prod_y;
  logic [DIVW-1:0]      rem_x, rem_y;
  logic signed [IW-1:0] cx, cy;

  logic signed [EW-1:0] lx_s, ly_s, ux_s, uy_s;
  logic                 right, bottom, in_lt, in_rt, in_lb, in_rb, in_diamond;
  logic [CORNER_W-1:0]  corner_nxt;

  logic                 is_pick;
  logic signed [IW-1:0] ic_step, ir_step, c_sel, r_sel;
  logic                 base_in, sel_in, hit_nxt;
  logic [AW-1:0]        col_part, row_part, addr_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic                 ram_wdata;
  logic                 ram_rdata;

  function automatic logic in_grid(logic signed [IW-1:0] c, logic signed [IW-1:0] r);
    return (c >= 0) && (c < COLS_S) && (r >= 0) && (r < ROWS_S);
  endfunction

  assign clear_done = (state_r != ST_CLR);
  assign pop        = (state_r == ST_IDLE) && !q_empty;
  assign load       = (state_r == ST_LOAD) && (!out_valid_r || !out_stall);

  // sequencer, clear sweep and output valid
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:  state_nxt = ST_REM;
      ST_REM:  state_nxt = ST_EDGE;
      ST_EDGE: state_nxt = ST_STEP;
      ST_STEP: state_nxt = ST_MEM;
      ST_MEM:  state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // floor division by reciprocal multiply
  assign prod_x = (DIVW + SX)'(item_r.ax) * (DIVW + SX)'(MX);
  assign prod_y = (DIVW + SY)'(item_r.ay) * (DIVW + SY)'(MY);

  // remainder inside the box and rotation to iso indices
  assign rem_x = item_r.ax - qx_r * DIVW'(BOX_W);
  assign rem_y = item_r.ay - qy_r * DIVW'(BOX_H);
  assign cx    = $signed(IW'(qx_r)) - KX_S;
  assign cy    = $signed(IW'(qy_r)) - KY_S;

  // quadrant and diamond edge test by cross-multiplication
  assign lx_s   = $signed(EW'(lx_r));
  assign ly_s   = $signed(EW'(ly_r));
  assign ux_s   = lx_s - HTW_S;
  assign uy_s   = ly_s - HTH_S;
  assign right  = (lx_s >= HTW_S);
  assign bottom = (ly_s >= HTH_S);
  assign in_lt  = (HTW_S * (HTH_S - ly_s)) <= (lx_s * HTH_S);
  assign in_rt  = (ly_s * HTW_S) >= (ux_s * HTH_S);
  assign in_lb  = (uy_s * HTW_S) < (lx_s * HTH_S);
  assign in_rb  = (HTW_S * (HTH_S - uy_s)) > (ux_s * HTH_S);

  always_comb begin
    priority if (!right && !bottom) begin
      in_diamond = in_lt;
      corner_nxt = CORNER_LT;
    end else if (right && !bottom) begin
      in_diamond = in_rt;
      corner_nxt = CORNER_RT;
    end else if (!right) begin
      in_diamond = in_lb;
      corner_nxt = CORNER_LB;
    end else begin
      in_diamond = in_rb;
      corner_nxt = CORNER_RB;
    end
    if (in_diamond) begin
      corner_nxt = CORNER_NONE;
    end
  end

  // neighbor step, grid checks and bitmap address
  assign is_pick = (item_r.op == OP_PICK);
  assign ic_step = ic_r + IW'(corner_r == CORNER_RB) - IW'(corner_r == CORNER_LT);
  assign ir_step = ir_r + IW'(corner_r == CORNER_LB) - IW'(corner_r == CORNER_RT);
  assign c_sel   = is_pick ? ic_step : $signed(IW'(item_r.qc));
  assign r_sel   = is_pick ? ir_step : $signed(IW'(item_r.qr));
  assign base_in = in_grid(ic_r, ir_r);
  assign sel_in  = in_grid(c_sel, r_sel);
  assign hit_nxt = is_pick && base_in && sel_in;

  assign col_part = AW'(c_sel[CW-1:0]);
  assign row_part = AW'(r_sel[RW-1:0]);
  assign addr_nxt = AW'(col_part * AW'(GRID_ROWS)) + row_part;

  // item datapath registers, each loaded in its own step
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item;
    end
    if (state_r == ST_DIV) begin
      qx_r <= prod_x[SX +: DIVW];
      qy_r <= prod_y[SY +: DIVW];
    end
    if (state_r == ST_REM) begin
      lx_r <= rem_x[BXW-1:0];
      ly_r <= rem_y[BYW-1:0];
      ic_r <= cx + cy;
      ir_r <= cy - cx;
    end
    if (state_r == ST_EDGE) begin
      corner_r <= corner_nxt;
    end
    if (state_r == ST_STEP) begin
      hit_r  <= hit_nxt;
      look_r <= !is_pick && sel_in;
      addr_r <= addr_nxt;
      col_r  <= (is_pick && !hit_nxt) ? '0 : c_sel[IDX_W-1:0];
      row_r  <= (is_pick && !hit_nxt) ? '0 : r_sel[IDX_W-1:0];
      cor_r  <= hit_nxt ? corner_r : CORNER_NONE;
    end
    if (load) begin
      out_hit_r    <= hit_r;
      out_col_r    <= col_r;
      out_row_r    <= row_r;
      out_corner_r <= cor_r;
      out_marked_r <= hit_r || (look_r && ram_rdata);
    end
  end

  // bitmap: clear sweep after reset, mark on a hit, read every cycle
  assign ram_we    = (state_r == ST_CLR) || ((state_r == ST_MEM) && hit_r);
  assign ram_waddr = (state_r == ST_CLR) ? clr_cnt_r : addr_r;
  assign ram_wdata = (state_r != ST_CLR);

  itp_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_tile_col = out_col_r;
  assign out_tile_row = out_row_r;
  assign out_corner   = out_corner_r;
  assign out_marked   = out_marked_r;

endmodule
